@@ sv/msp_pkg.sv @@
`default_nettype none
package msp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_SYSEX = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Active sensing states
  localparam logic [1:0] SENSE_OFF    = 2'd0;
  localparam logic [1:0] SENSE_ON     = 2'd1;
  localparam logic [1:0] SENSE_FAILED = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SENSE_TIMEOUT = 1'b0;
  localparam logic CFG_WINDOW_LAST   = 1'b1;

  // MIDI codes
  localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
  localparam logic [7:0] ST_NOTE_ON    = 8'h90;
  localparam logic [7:0] ST_POLY_AT    = 8'hA0;
  localparam logic [7:0] ST_CTRL       = 8'hB0;
  localparam logic [7:0] ST_PROG       = 8'hC0;
  localparam logic [7:0] ST_CHAN_AT    = 8'hD0;
  localparam logic [7:0] ST_BEND       = 8'hE0;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_MTC        = 8'hF1;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
  localparam logic [7:0] ST_TUNE       = 8'hF6;
  localparam logic [7:0] ST_EOX        = 8'hF7;
  localparam logic [7:0] ST_CLOCK      = 8'hF8;
  localparam logic [7:0] ST_START      = 8'hFA;
  localparam logic [7:0] ST_CONTINUE   = 8'hFB;
  localparam logic [7:0] ST_STOP       = 8'hFC;
  localparam logic [7:0] ST_SENSING    = 8'hFE;
  localparam logic [7:0] ST_RESET      = 8'hFF;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] rx_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  msg_type;
    logic [4:0]  channel;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [6:0]  byte_count;
    logic [31:0] time_stamp;
    logic [7:0]  sysex_byte;
    logic        last;
    logic [1:0]  sense_state;
    logic [15:0] rate_count;
  } out_t;

  // Front-to-back commands. For a store write the address rides in
  // byte_count and the data in sysex_byte; a run carries its length in
  // byte_count.
  typedef enum logic [1:0] {
    OP_MSG,
    OP_WR,
    OP_RUN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    out_t    res;
  } cmd_t;

  function automatic logic [7:0] type_of(input logic [7:0] b);
    if (!b[7]) return 8'h00;
    if (b[7:4] == 4'hF) return b;
    return {b[7:4], 4'h0};
  endfunction

  function automatic logic is_channel(input logic [7:0] t);
    return t[7] && (t[7:4] != 4'hF);
  endfunction

endpackage
`default_nettype wire

@@ sv/msp_front.sv @@
`default_nettype none
module msp_front #(
  parameter int SYSEX_MAX = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire msp_pkg::in_t in_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [3:0]   cfg_data,
  output logic              cmd_push,
  output msp_pkg::cmd_t     cmd_data,
  input  wire logic         cmd_full
);
  import msp_pkg::*;

  localparam logic [6:0] LEN_MAX = 7'(SYSEX_MAX);

  logic [2:0]  timeout_r;
  logic [3:0]  wlt_r;
  logic [7:0]  ps_r, ps_nxt;
  logic [7:0]  pd0_r, pd0_nxt;
  logic [7:0]  pd1_r, pd1_nxt;
  logic [6:0]  pidx_r, pidx_nxt;
  logic [6:0]  el_r, el_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [31:0] sxt_r, sxt_nxt;
  logic [1:0]  sense_r, sense_nxt;
  logic [2:0]  idle_r, idle_nxt;
  logic [3:0]  tc_r, tc_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] rate_r, rate_nxt;

  logic        accept;
  logic        emit;
  logic        count;
  cmd_t        cmd;

  // combinational helper variables
  logic [7:0]  b, ps_c, pd0_c, t_c;
  logic [31:0] ts;
  logic [6:0]  pidx_c, el_c;
  logic        go, sx, data_path, chan;
  logic [2:0]  idle_c;

  function automatic out_t mk(input logic [1:0] kind, input logic [7:0] mt,
                              input logic [4:0] ch, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [6:0] cnt,
                              input logic [31:0] t, input logic [7:0] sxb,
                              input logic lst);
    out_t o;
    o             = '0;
    o.result_kind = kind;
    o.msg_type    = mt;
    o.channel     = ch;
    o.data_one    = d1;
    o.data_two    = d2;
    o.byte_count  = cnt;
    o.time_stamp  = t;
    o.sysex_byte  = sxb;
    o.last        = lst;
    return o;
  endfunction

  assign accept  = in_push && !cmd_full;
  assign in_full = cmd_full;

  // parser step
  always_comb begin
    ps_nxt = ps_r; pd0_nxt = pd0_r; pd1_nxt = pd1_r; pidx_nxt = pidx_r;
    el_nxt = el_r; rs_nxt = rs_r; sxt_nxt = sxt_r; sense_nxt = sense_r;
    idle_nxt = idle_r; tc_nxt = tc_r; start_nxt = start_r; rate_nxt = rate_r;
    emit = 1'b0; count = 1'b0; cmd = '0; cmd.op = OP_MSG;
    b = in_data.rx_byte; ts = in_data.rx_time;
    ps_c = '0; pd0_c = '0; t_c = '0; pidx_c = '0; el_c = '0;
    go = 1'b0; sx = 1'b0; data_path = 1'b0; chan = 1'b0; idle_c = '0;

    if (in_data.req_type) begin
      // tick: rate window and sensing timeout
      if (tc_r == wlt_r) begin
        tc_nxt    = '0;
        rate_nxt  = total_r - start_r;
        start_nxt = total_r;
      end else begin
        tc_nxt = tc_r + 4'd1;
      end
      if (sense_r == SENSE_ON) begin
        idle_c   = (idle_r == 3'd7) ? idle_r : idle_r + 3'd1;
        idle_nxt = idle_c;
        if (idle_c > timeout_r) sense_nxt = SENSE_FAILED;
      end
      emit    = 1'b1;
      cmd.res = mk(KIND_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    end else if (pidx_r == '0) begin
      idle_nxt = '0;
      // nothing pending: new status or running-status data
      ps_c = b; pd0_c = pd0_r; pidx_c = '0;
      if (is_channel(type_of(rs_r)) && !b[7]) begin
        ps_c = rs_r; pd0_c = b; pidx_c = 7'd1;
      end
      ps_nxt = ps_c; pd0_nxt = pd0_c; pidx_nxt = pidx_c;
      t_c = type_of(ps_c);
      unique case (t_c)
        ST_SENSING: begin
          sense_nxt = SENSE_ON;
          emit = 1'b1; count = 1'b1;
          cmd.res = mk(KIND_MSG, t_c, '0, '0, '0, 7'd1, ts, '0, 1'b1);
          pidx_nxt = '0; el_nxt = '0;
        end
        ST_START, ST_CONTINUE, ST_STOP, ST_CLOCK, ST_RESET, ST_TUNE: begin
          emit = 1'b1; count = 1'b1;
          cmd.res = mk(KIND_MSG, t_c, '0, '0, '0, 7'd1, ts, '0, 1'b1);
          pidx_nxt = '0; el_nxt = '0;
        end
        ST_PROG, ST_CHAN_AT, ST_MTC, ST_SONG_SEL: begin
          el_c = 7'd2; go = 1'b1;
        end
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_BEND, ST_SONG_POS: begin
          el_c = 7'd3; go = 1'b1;
        end
        ST_SYSEX: begin
          el_c = LEN_MAX; go = 1'b1; rs_nxt = '0; sxt_nxt = ts;
        end
        default: begin
          pidx_nxt = '0; el_nxt = '0; rs_nxt = '0;
        end
      endcase
      if (go) begin
        el_nxt = el_c;
        if (pidx_c + 7'd1 >= el_c) begin
          emit = 1'b1; count = 1'b1;
          cmd.res = mk(KIND_MSG, t_c, {1'b0, ps_c[3:0]} + 5'd1, pd0_c,
                       (el_c == 7'd3) ? pd1_r : 8'h00,
                       (el_c == 7'd3) ? 7'd3 : 7'd2, ts, '0, 1'b1);
          pidx_nxt = '0; el_nxt = '0;
        end else begin
          pidx_nxt = pidx_c + 7'd1;
        end
      end
    end else begin
      idle_nxt = '0;
      // message pending
      sx = (ps_r == ST_SYSEX);
      data_path = 1'b1;
      if (b[7]) begin
        unique case (b)
          ST_SENSING: begin
            sense_nxt = SENSE_ON; emit = 1'b1; data_path = 1'b0;
            cmd.res = mk(KIND_MSG, b, '0, '0, '0, 7'd1, ts, '0, 1'b1);
          end
          ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_RESET: begin
            emit = 1'b1; data_path = 1'b0;
            cmd.res = mk(KIND_MSG, b, '0, '0, '0, 7'd1, ts, '0, 1'b1);
          end
          ST_EOX: begin
            data_path = 1'b0;
            if (sx && pidx_r < LEN_MAX) begin
              emit = 1'b1; count = 1'b1;
              cmd.op  = OP_RUN;
              cmd.res = mk(KIND_MSG, ST_SYSEX, '0, '0, '0, pidx_r + 7'd1,
                           sxt_r, '0, 1'b1);
            end
            pidx_nxt = '0; el_nxt = '0; rs_nxt = '0;
          end
          default: ;
        endcase
      end
      if (data_path) begin
        if (sx) begin
          if (pidx_r + 7'd1 >= el_r) begin
            // buffer overflow: abort
            pidx_nxt = '0; el_nxt = '0; rs_nxt = '0;
          end else begin
            emit = 1'b1;
            cmd.op  = OP_WR;
            cmd.res = mk(KIND_SYSEX, '0, '0, '0, '0, pidx_r, '0, b, 1'b0);
            pidx_nxt = pidx_r + 7'd1;
          end
        end else begin
          if (pidx_r == 7'd1) pd0_nxt = b;
          if (pidx_r == 7'd2) pd1_nxt = b;
          if (pidx_r + 7'd1 >= el_r) begin
            chan = is_channel(type_of(ps_r));
            emit = 1'b1; count = 1'b1;
            cmd.res = mk(KIND_MSG, type_of(ps_r),
                         chan ? ({1'b0, ps_r[3:0]} + 5'd1) : 5'd0, pd0_nxt,
                         (el_r == 7'd3) ? pd1_nxt : 8'h00,
                         (el_r == 7'd3) ? 7'd3 : 7'd2, ts, '0, 1'b1);
            pidx_nxt = '0; el_nxt = '0;
            rs_nxt = chan ? ps_r : 8'h00;
          end else begin
            pidx_nxt = pidx_r + 7'd1;
          end
        end
      end
    end

    total_nxt = (count && total_r != 16'hFFFF) ? total_r + 16'd1 : total_r;
    cmd.res.sense_state = sense_nxt;
    cmd.res.rate_count  = rate_nxt;
  end

  assign cmd_push = accept && emit;
  assign cmd_data = cmd;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 3'd3; wlt_r <= 4'd10;
      ps_r <= '0; pd0_r <= '0; pd1_r <= '0; pidx_r <= '0; el_r <= '0;
      rs_r <= '0; sxt_r <= '0; sense_r <= SENSE_OFF; idle_r <= '0;
      tc_r <= '0; total_r <= '0; start_r <= '0; rate_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SENSE_TIMEOUT) timeout_r <= cfg_data[2:0];
        if (cfg_idx == CFG_WINDOW_LAST)   wlt_r     <= cfg_data;
      end
      if (accept) begin
        ps_r <= ps_nxt; pd0_r <= pd0_nxt; pd1_r <= pd1_nxt;
        pidx_r <= pidx_nxt; el_r <= el_nxt; rs_r <= rs_nxt;
        sxt_r <= sxt_nxt; sense_r <= sense_nxt; idle_r <= idle_nxt;
        tc_r <= tc_nxt; total_r <= total_nxt; start_r <= start_nxt;
        rate_r <= rate_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/msp_cmd_fifo.sv @@
`default_nettype none
module msp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire msp_pkg::cmd_t data_in,
  output logic               full,
  input  wire logic          pop,
  output msp_pkg::cmd_t      data_out,
  output logic               empty
);
  import msp_pkg::*;

  cmd_t       entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = entry_r[rp_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wp_r] <= data_in;
  end

endmodule
`default_nettype wire

@@ sv/msp_back.sv @@
`default_nettype none
module msp_back #(
  parameter int SYSEX_MAX = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty,
  input  wire msp_pkg::cmd_t cmd_data,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output msp_pkg::out_t      out_data
);
  import msp_pkg::*;

  localparam int AW = $clog2(SYSEX_MAX);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t      state_r;
  logic        out_valid_r;
  out_t        res_r;
  out_t        run_r;
  logic [6:0]  k_r;
  logic [7:0]  rd_data_r;
  logic [7:0]  mem [SYSEX_MAX];
  logic        out_free;
  logic        wr_en;
  logic        out_load;
  out_t        load_res;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = res_r;
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty &&
                     (cmd_data.op != OP_MSG || out_free);
  assign wr_en     = cmd_pop && cmd_data.op == OP_WR;

  // SysEx store
  always_ff @(posedge clk) begin
    if (wr_en) mem[cmd_data.res.byte_count[AW-1:0]] <= cmd_data.res.sysex_byte;
    rd_data_r <= mem[k_r[AW-1:0]];
  end

  // next result for the output register
  always_comb begin
    out_load = 1'b0;
    load_res = run_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_pop && cmd_data.op == OP_MSG) begin
          out_load = 1'b1;
          load_res = cmd_data.res;
        end
      end
      S_READ: begin
        if (!(k_r + 7'd1 < run_r.byte_count) && out_free) begin
          // length summary
          out_load          = 1'b1;
          load_res.data_one = {1'b0, run_r.byte_count};
          load_res.data_two = 8'h00;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          load_res.result_kind = KIND_SYSEX;
          load_res.byte_count  = '0;
          load_res.sysex_byte  = rd_data_r;
          load_res.last        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_pop);
      if (out_load) res_r <= load_res;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd_data.op == OP_RUN) begin
            run_r <= cmd_data.res; k_r <= 7'd1; state_r <= S_READ;
          end
        end
        S_READ: begin
          if (k_r + 7'd1 < run_r.byte_count) begin
            state_r <= S_EMIT;
          end else if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            k_r     <= k_r + 7'd1;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/midi_stream_parser_core.sv @@
`default_nettype none
// MIDI stream parser.
// Input queue side: push an item (a received byte with its timestamp, or a
// 100 ms tick) when full is low. Result queue side: the oldest result sits
// on out_data while out_empty is low and is taken with out_pop.
// Configuration: cfg_we with cfg_idx 0 (sensing timeout) or 1 (last tick
// of the rate window); write only while the block is idle.
// A front stage parses one item per cycle while the queue is not full and
// posts at most one command per item into a two-entry queue; a back stage
// turns commands into results through a one-entry output register, so a
// result passes through the queue entry and then the output register, and
// bytes flow at one per cycle while results drain and no run is being read.
// For an EOX run, the back stage takes the command, reads and emits each
// stored byte in turn via the registered SysEx buffer read, then loads the
// summary; the front stalls (full high) once the queue fills behind it.
// Reset clears the parser, counters and queues and loads the register
// defaults; the SysEx buffer is not cleared. When the receiver stalls,
// results wait in the output register, then the queue, then full rises.
module midi_stream_parser_core #(
  parameter int SYSEX_MAX = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire msp_pkg::in_t in_data,
  output logic              out_empty,
  input  wire logic         out_pop,
  output msp_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [3:0]   cfg_data
);
  import msp_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  msp_front #(.SYSEX_MAX(SYSEX_MAX)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cfg_we, .cfg_idx, .cfg_data,
    .cmd_push, .cmd_data(cmd_in), .cmd_full
  );

  msp_cmd_fifo u_fifo (
    .clk, .rst_n, .push(cmd_push), .data_in(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .data_out(cmd_out), .empty(cmd_empty)
  );

  msp_back #(.SYSEX_MAX(SYSEX_MAX)) u_back (
    .clk, .rst_n, .cmd_empty, .cmd_data(cmd_out), .cmd_pop,
    .out_empty, .out_pop, .out_data
  );

endmodule
`default_nettype wire
